FILE: src/pfa_pkg.sv
// Shared types and constants of the partition fit allocator.
// Used by the slot cell, the core and the port checker.
package pfa_pkg;

  // Geometry
  localparam int NUM_SLOTS = 8;
  localparam int SIZE_BITS = 16;
  localparam int REQ_BITS  = 16;
  localparam int CMP_W     = (SIZE_BITS > REQ_BITS) ? SIZE_BITS : REQ_BITS;
  localparam int IDX_W     = ($clog2(NUM_SLOTS) > 3) ? $clog2(NUM_SLOTS) : 3;

  localparam logic [CMP_W-1:0] SIZE_MAX_C = CMP_W'((64'd1 << SIZE_BITS) - 64'd1);

  // Item kinds
  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_REQ  = 1'b1;

  // Fit policies; the unused code behaves as first fit
  localparam logic [1:0] POL_FIRST = 2'd0;
  localparam logic [1:0] POL_BEST  = 2'd1;
  localparam logic [1:0] POL_WORST = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_HOLD
  } state_t;

  typedef struct packed {
    logic        kind;
    logic [2:0]  slot;
    logic [15:0] size;
    logic [7:0]  process_id;
  } in_t;

  typedef struct packed {
    logic       found;
    logic [2:0] granted_slot;
    logic [7:0] granted_process;
  } out_t;

  // Search record handed from cell to cell
  typedef struct packed {
    logic                 valid;
    logic [CMP_W-1:0]     want;
    logic                 have;
    logic [SIZE_BITS-1:0] best_size;
    logic [IDX_W-1:0]     best_idx;
  } rec_t;

  // Load broadcast to all cells
  typedef struct packed {
    logic                 en;
    logic [IDX_W-1:0]     slot;
    logic [SIZE_BITS-1:0] size;
  } load_t;

  // Grant broadcast to all cells
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] idx;
  } grant_t;

  // Clamp a loaded size to the stored width
  function automatic logic [SIZE_BITS-1:0] sat_size(input logic [REQ_BITS-1:0] sz);
    logic [CMP_W-1:0] wide;
    wide = CMP_W'(sz);
    if (wide > SIZE_MAX_C) begin
      wide = SIZE_MAX_C;
    end
    return SIZE_BITS'(wide);
  endfunction

endpackage

FILE: src/pfa_cell.sv
// One partition slot: size, loaded and taken flags, plus one search step.
// Depends on pfa_pkg.
module pfa_cell
  import pfa_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic [IDX_W-1:0] cell_idx,
  input  logic [1:0]       fit_policy,
  input  load_t            load,
  input  grant_t           grant,
  input  rec_t             rec_in,
  output rec_t             rec_out
);

  logic [SIZE_BITS-1:0] size_q;
  logic                 loaded;
  logic                 taken;
  logic                 fits;
  logic                 take;

  // Slot state: a load frees the slot, a grant takes it
  always_ff @(posedge clk) begin
    if (load.en && load.slot == cell_idx) begin
      size_q <= load.size;
    end
    if (rst) begin
      loaded <= 1'b0;
      taken  <= 1'b0;
    end else if (load.en && load.slot == cell_idx) begin
      loaded <= 1'b1;
      taken  <= 1'b0;
    end else if (grant.en && grant.idx == cell_idx) begin
      taken <= 1'b1;
    end
  end

  // Search step; strict compares keep ties at the lower index
  always_comb begin
    fits = loaded && !taken && (CMP_W'(size_q) >= rec_in.want);
    take = fits && (!rec_in.have ||
                    (fit_policy == POL_BEST  && size_q < rec_in.best_size) ||
                    (fit_policy == POL_WORST && size_q > rec_in.best_size));
  end

  // Hand the record to the next cell
  always_ff @(posedge clk) begin
    rec_out.want      <= rec_in.want;
    rec_out.have      <= rec_in.have || fits;
    rec_out.best_size <= take ? size_q : rec_in.best_size;
    rec_out.best_idx  <= take ? cell_idx : rec_in.best_idx;
    if (rst) begin
      rec_out.valid <= 1'b0;
    end else begin
      rec_out.valid <= rec_in.valid;
    end
  end

endmodule

FILE: src/partition_fit_allocator_core.sv
// Partition fit allocator: a row of slot cells scanned by a travelling record.
// Usage summary below. Depends on pfa_pkg and pfa_cell.
//
// Channels: in (in_valid/in_ready/in_data) carries load and request
// transactions; out (out_valid/out_ready/out_data) carries one result per
// request; cfg (cfg_valid/cfg_ready/cfg_data) writes the fit policy and is
// always ready. Write the policy only while the block is idle.
// A load transaction writes its slot in the accept cycle and yields no result;
// the block is ready again in the next cycle.
// A request enters the first cell on acceptance and moves one cell per cycle
// down the NUM_SLOTS-cell row; at the end of the row its result goes to the
// output register, or to the hold register while the receiver stalls. The
// block accepts no new request until its state has returned to idle.
// The granted slot is marked taken as the result is registered.
// When the receiver stalls, a finished result waits in a hold register and
// the input stays blocked only until the output register frees.
// Reset clears all loaded and taken flags, the policy (first fit) and the
// output valid; sizes hold no value until loaded.
module partition_fit_allocator_core
  import pfa_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_t        in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output out_t       out_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_data
);

  state_t     state;
  state_t     state_next;
  logic [1:0] fit_policy;
  logic [7:0] pid;
  out_t       res_new;
  out_t       res_hold;
  logic       out_free;
  logic       out_load;
  logic       out_from_hold;
  logic       hold_load;
  load_t      load;
  grant_t     grant;
  rec_t       rec [NUM_SLOTS+1];

  assign cfg_ready = 1'b1;

  // Policy register
  always_ff @(posedge clk) begin
    if (rst) begin
      fit_policy <= POL_FIRST;
    end else if (cfg_valid && cfg_ready) begin
      fit_policy <= cfg_data;
    end
  end

  // Load broadcast and search launch
  always_comb begin
    load.en   = in_valid && in_ready && in_data.kind == KIND_LOAD;
    load.slot = IDX_W'(in_data.slot);
    load.size = sat_size(in_data.size);

    rec[0].valid     = in_valid && in_ready && in_data.kind == KIND_REQ;
    rec[0].want      = CMP_W'(in_data.size);
    rec[0].have      = 1'b0;
    rec[0].best_size = '0;
    rec[0].best_idx  = '0;
  end

  // Row of slot cells
  for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_cell
    pfa_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .cell_idx   (IDX_W'(i)),
      .fit_policy (fit_policy),
      .load       (load),
      .grant      (grant),
      .rec_in     (rec[i]),
      .rec_out    (rec[i+1])
    );
  end

  // Result of the finished scan
  always_comb begin
    res_new.found           = rec[NUM_SLOTS].have;
    res_new.granted_slot    = rec[NUM_SLOTS].have ? rec[NUM_SLOTS].best_idx[2:0] : 3'd0;
    res_new.granted_process = pid;
  end

  // Control: next state and handshakes
  always_comb begin
    state_next    = state;
    in_ready      = 1'b0;
    grant.en      = 1'b0;
    grant.idx     = rec[NUM_SLOTS].best_idx;
    out_load      = 1'b0;
    out_from_hold = 1'b0;
    hold_load     = 1'b0;
    out_free      = !out_valid || out_ready;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid && in_data.kind == KIND_REQ) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (rec[NUM_SLOTS].valid) begin
          grant.en = rec[NUM_SLOTS].have;
          if (out_free) begin
            out_load   = 1'b1;
            state_next = ST_IDLE;
          end else begin
            hold_load  = 1'b1;
            state_next = ST_HOLD;
          end
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          out_load      = 1'b1;
          out_from_hold = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Request id, hold register and output register
  always_ff @(posedge clk) begin
    if (rec[0].valid) begin
      pid <= in_data.process_id;
    end
    if (hold_load) begin
      res_hold <= res_new;
    end
    if (out_load) begin
      out_data <= out_from_hold ? res_hold : res_new;
    end
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

FILE: src/pfa_port_check.sv
// Port-level checks for the partition fit allocator core, bound to the top.
// Depends on pfa_pkg.
module pfa_port_check
  import pfa_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input in_t        in_data,
  input logic       out_valid,
  input logic       out_ready,
  input out_t       out_data,
  input logic       cfg_ready
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // A miss reports slot zero
  a_miss_slot: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.found |-> out_data.granted_slot == 3'd0)
    else $error("miss with nonzero slot");

  // A request transaction blocks the input while it scans
  a_req_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_data.kind == KIND_REQ |=> !in_ready)
    else $error("input ready during scan");

  // A load transaction leaves the input ready
  a_load_ready: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_data.kind == KIND_LOAD |=> in_ready)
    else $error("input blocked after load");

  // Config port is always open
  a_cfg_ready: assert property (@(posedge clk) disable iff (rst) cfg_ready)
    else $error("config port not ready");

endmodule

bind partition_fit_allocator_core pfa_port_check u_pfa_port_check (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data),
  .cfg_ready (cfg_ready)
);
